// ===== hdl/hgc_pkg.sv =====
// Package for the two-set Hangul composer: jamo key tables, combining rules,
// syllable composition and the request/result codes.
// No dependencies; the composer top level refers to it by scoped names.
`default_nettype none

package hgc_pkg;

	typedef logic [4:0]  idx_t;
	typedef logic [1:0]  kind_t;
	typedef logic [1:0]  req_t;
	typedef logic [15:0] code_t;

	typedef struct packed {
		kind_t kind;
		code_t code;
	} res_t;

	// request codes
	localparam req_t REQ_KEY   = 2'd0;
	localparam req_t REQ_BKSP  = 2'd1;
	localparam req_t REQ_FLUSH = 2'd2;

	// result kinds
	localparam kind_t KIND_COMMIT  = 2'd0;
	localparam kind_t KIND_ERASE   = 2'd1;
	localparam kind_t KIND_PREEDIT = 2'd2;

	localparam idx_t NONE = 5'd31;

	localparam idx_t CHO_COUNT  = 5'd19;
	localparam idx_t JUNG_COUNT = 5'd21;
	localparam idx_t JONG_COUNT = 5'd28;

	localparam code_t SYL_BASE    = 16'hAC00;
	localparam code_t CHO_STRIDE  = 16'd588;
	localparam code_t JUNG_STRIDE = 16'd28;
	localparam code_t VOWEL_BASE  = 16'h314F;

	typedef idx_t  tab_t  [32];
	typedef code_t ctab_t [32];

	// letter tables, indexed by letter position (a/A = 0), padded to 32
	localparam tab_t CHO_LO = '{
		5'd6, NONE, 5'd14, 5'd11, 5'd3, 5'd5, 5'd18, NONE,
		NONE, NONE, NONE, NONE, NONE, NONE, NONE, NONE,
		5'd7, 5'd0, 5'd2, 5'd9, NONE, 5'd17, 5'd12, 5'd16,
		NONE, 5'd15, NONE, NONE, NONE, NONE, NONE, NONE};
	localparam tab_t CHO_UP = '{
		NONE, NONE, NONE, NONE, 5'd4, NONE, NONE, NONE,
		NONE, NONE, NONE, NONE, NONE, NONE, NONE, NONE,
		5'd8, 5'd1, NONE, 5'd10, NONE, NONE, 5'd13, NONE,
		NONE, NONE, NONE, NONE, NONE, NONE, NONE, NONE};
	localparam tab_t JUNG_LO = '{
		NONE, 5'd17, NONE, NONE, NONE, NONE, NONE, 5'd8,
		5'd2, 5'd4, 5'd0, 5'd20, 5'd18, 5'd13, 5'd1, 5'd5,
		NONE, NONE, NONE, NONE, 5'd6, NONE, NONE, NONE,
		5'd12, NONE, NONE, NONE, NONE, NONE, NONE, NONE};
	localparam tab_t JUNG_UP = '{
		NONE, NONE, NONE, NONE, NONE, NONE, NONE, NONE,
		NONE, NONE, NONE, NONE, NONE, NONE, 5'd3, 5'd7,
		NONE, NONE, NONE, NONE, NONE, NONE, NONE, NONE,
		NONE, NONE, NONE, NONE, NONE, NONE, NONE, NONE};
	localparam tab_t JONG_LO = '{
		5'd16, NONE, 5'd23, 5'd21, 5'd7, 5'd8, 5'd27, NONE,
		NONE, NONE, NONE, NONE, NONE, NONE, NONE, NONE,
		5'd17, 5'd1, 5'd4, 5'd19, NONE, 5'd26, 5'd22, 5'd25,
		NONE, 5'd24, NONE, NONE, NONE, NONE, NONE, NONE};
	localparam tab_t JONG_UP = '{
		NONE, NONE, NONE, NONE, NONE, NONE, NONE, NONE,
		NONE, NONE, NONE, NONE, NONE, NONE, NONE, NONE,
		NONE, 5'd2, NONE, 5'd20, NONE, NONE, NONE, NONE,
		NONE, NONE, NONE, NONE, NONE, NONE, NONE, NONE};

	// compatibility jamo for a lone initial
	localparam ctab_t CHO_COMPAT = '{
		16'h3131, 16'h3132, 16'h3134, 16'h3137, 16'h3138, 16'h3139, 16'h3141, 16'h3142,
		16'h3143, 16'h3145, 16'h3146, 16'h3147, 16'h3148, 16'h3149, 16'h314A, 16'h314B,
		16'h314C, 16'h314D, 16'h314E, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
		16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000};

	// final consonant -> same consonant as an initial
	localparam tab_t FIN_TO_INI = '{
		NONE, 5'd0, 5'd1, NONE, 5'd2, NONE, NONE, 5'd3,
		5'd5, NONE, NONE, NONE, NONE, NONE, NONE, NONE,
		5'd6, 5'd7, NONE, 5'd9, 5'd10, 5'd11, 5'd12, 5'd14,
		5'd15, 5'd16, 5'd17, 5'd18, NONE, NONE, NONE, NONE};

	// compound final -> part that stays and part that moves (zero: not compound)
	localparam tab_t SPLIT_KEEP = '{
		5'd0, 5'd0, 5'd0, 5'd1, 5'd0, 5'd4, 5'd4, 5'd0,
		5'd0, 5'd8, 5'd8, 5'd8, 5'd8, 5'd8, 5'd8, 5'd8,
		5'd0, 5'd0, 5'd17, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0,
		5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0};
	localparam tab_t SPLIT_MOVE = '{
		5'd0, 5'd0, 5'd0, 5'd19, 5'd0, 5'd22, 5'd27, 5'd0,
		5'd0, 5'd1, 5'd16, 5'd17, 5'd19, 5'd25, 5'd26, 5'd27,
		5'd0, 5'd0, 5'd19, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0,
		5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0};

	function automatic idx_t combine_medial(idx_t a, idx_t b);
		idx_t r;
		r = NONE;
		if (a == 5'd8) begin
			if (b == 5'd0) r = 5'd9;
			else if (b == 5'd1) r = 5'd10;
			else if (b == 5'd20) r = 5'd11;
		end else if (a == 5'd13) begin
			if (b == 5'd4) r = 5'd14;
			else if (b == 5'd5) r = 5'd15;
			else if (b == 5'd20) r = 5'd16;
		end else if (a == 5'd18 && b == 5'd20) begin
			r = 5'd19;
		end
		return r;
	endfunction

	function automatic idx_t combine_final(idx_t a, idx_t b);
		idx_t r;
		r = NONE;
		if (a == 5'd1 && b == 5'd19) begin
			r = 5'd3;
		end else if (a == 5'd4) begin
			if (b == 5'd22) r = 5'd5;
			else if (b == 5'd27) r = 5'd6;
		end else if (a == 5'd8) begin
			case (b)
				5'd1:    r = 5'd9;
				5'd16:   r = 5'd10;
				5'd17:   r = 5'd11;
				5'd19:   r = 5'd12;
				5'd25:   r = 5'd13;
				5'd26:   r = 5'd14;
				5'd27:   r = 5'd15;
				default: r = NONE;
			endcase
		end else if (a == 5'd17 && b == 5'd19) begin
			r = 5'd18;
		end
		return r;
	endfunction

	// character shown for a composition; zero when empty
	function automatic code_t compose(idx_t ini, idx_t med, idx_t fin);
		logic  hc;
		logic  hm;
		code_t fv;
		code_t r;
		hc = ini < CHO_COUNT;
		hm = med < JUNG_COUNT;
		fv = (fin < JONG_COUNT) ? 16'(fin) : 16'd0;
		if (hc && !hm)
			r = CHO_COMPAT[ini];
		else if (hc && hm)
			r = SYL_BASE + 16'(ini) * CHO_STRIDE + 16'(med) * JUNG_STRIDE + fv;
		else if (hm)
			r = VOWEL_BASE + 16'(med);
		else
			r = 16'd0;
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/hangul_two_set_composer.sv =====
// Two-set Hangul keyboard composer: top level with input register, composition
// automaton and a three-deep result queue. Depends on hgc_pkg (scoped names).
`default_nettype none

//  channel | handshake             | payload                      | beat
//  --------+-----------------------+------------------------------+------------------------
//  request | key_valid / key_stall | req_type, key_code           | one keystroke/bksp/flush
//  result  | res_valid / res_stall | out_kind, char_code, last    | one output character
//
//  A request is registered, then processed once the queue is free: the automaton updates
//  the syllable state and loads one to three results into the result queue.
//  Results leave one per cycle while res_stall is low, one beat per result of
//  the request; its first result passes the input register, then the queue.
//  Reset empties both stages and sets the composition to empty (all indices none).
//  A stall on the result port holds the queue; the request register then holds
//  and key_stall rises until the queue's final beat is taken.

module hangul_two_set_composer (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// request channel
	input  wire logic               key_valid,
	output logic                    key_stall,
	input  wire hgc_pkg::req_t      req_type,
	input  wire logic [7:0]         key_code,
	// result channel
	output logic                    res_valid,
	input  wire logic               res_stall,
	output hgc_pkg::kind_t          out_kind,
	output hgc_pkg::code_t          char_code,
	output logic                    last
);

	// ---------------------------------------------------------------
	// Input register
	// ---------------------------------------------------------------
	logic           valid_s1;
	hgc_pkg::req_t  req_s1;
	logic [7:0]     key_s1;

	// composition state
	hgc_pkg::idx_t  ini_q, med_q, fin_q;

	// result queue: entry 0 is on the port, res_left_q counts pending beats
	hgc_pkg::res_t  res_s2 [3];
	logic [1:0]     res_left_q;

	logic           key_take;
	logic           res_take;
	logic           queue_free;
	logic           advance;

	assign res_take   = res_valid && !res_stall;
	// queue can take a new list when empty or its final beat leaves now
	assign queue_free = (res_left_q == 2'd0) || (res_left_q == 2'd1 && !res_stall);
	assign advance    = valid_s1 && queue_free;
	assign key_stall  = valid_s1 && !advance;
	assign key_take   = key_valid && !key_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (key_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (key_take) begin
			req_s1 <= req_type;
			key_s1 <= key_code;
		end
	end

	// ---------------------------------------------------------------
	// Key lookup: letter position is the low five bits minus one for
	// both cases. A shifted letter with no mapping of its own falls
	// back to the lower-case tables.
	// ---------------------------------------------------------------
	logic           is_lower, is_upper, up_none, use_lo;
	logic [4:0]     letter;
	hgc_pkg::idx_t  ic, im, ifn;

	always_comb begin
		is_lower = (key_s1 >= 8'h61) && (key_s1 <= 8'h7A);
		is_upper = (key_s1 >= 8'h41) && (key_s1 <= 8'h5A);
		letter   = key_s1[4:0] - 5'd1;
		up_none  = (hgc_pkg::CHO_UP[letter] == hgc_pkg::NONE) &&
		           (hgc_pkg::JUNG_UP[letter] == hgc_pkg::NONE) &&
		           (hgc_pkg::JONG_UP[letter] == hgc_pkg::NONE);
		use_lo   = is_lower || (is_upper && up_none);
		if (use_lo) begin
			ic  = hgc_pkg::CHO_LO[letter];
			im  = hgc_pkg::JUNG_LO[letter];
			ifn = hgc_pkg::JONG_LO[letter];
		end else if (is_upper) begin
			ic  = hgc_pkg::CHO_UP[letter];
			im  = hgc_pkg::JUNG_UP[letter];
			ifn = hgc_pkg::JONG_UP[letter];
		end else begin
			ic  = hgc_pkg::NONE;
			im  = hgc_pkg::NONE;
			ifn = hgc_pkg::NONE;
		end
	end

	// ---------------------------------------------------------------
	// Automaton. At most one composed commit per request; c_* is the state the
	// commit composes from (a compound final may be trimmed first).
	// ---------------------------------------------------------------
	logic           hc, hm, hf;
	logic           do_commit, raw_key, erase;
	hgc_pkg::idx_t  c_ini, c_med, c_fin;
	hgc_pkg::idx_t  n_ini, n_med, n_fin;
	hgc_pkg::idx_t  comb_m, comb_f, keep, move;

	always_comb begin
		hc = ini_q < hgc_pkg::CHO_COUNT;
		hm = med_q < hgc_pkg::JUNG_COUNT;
		hf = fin_q < hgc_pkg::JONG_COUNT;

		comb_m = hgc_pkg::combine_medial(med_q, im);
		comb_f = hgc_pkg::combine_final(fin_q, ifn);
		// a plain final moves whole
		if (hgc_pkg::SPLIT_MOVE[fin_q] == 5'd0) begin
			move = fin_q;
			keep = 5'd0;
		end else begin
			move = hgc_pkg::SPLIT_MOVE[fin_q];
			keep = hgc_pkg::SPLIT_KEEP[fin_q];
		end

		do_commit = 1'b0;
		raw_key   = 1'b0;
		erase     = 1'b0;
		c_ini     = ini_q;
		c_med     = med_q;
		c_fin     = fin_q;
		n_ini     = ini_q;
		n_med     = med_q;
		n_fin     = fin_q;

		unique case (req_s1)
			hgc_pkg::REQ_KEY: begin
				if (ic == hgc_pkg::NONE && im == hgc_pkg::NONE) begin
					// unmapped: commit, then pass the raw key through
					do_commit = 1'b1;
					raw_key   = 1'b1;
					n_ini     = hgc_pkg::NONE;
					n_med     = hgc_pkg::NONE;
					n_fin     = hgc_pkg::NONE;
				end else if (!hc) begin
					// empty, or a lone vowel that gets committed first
					do_commit = hm;
					n_fin     = hgc_pkg::NONE;
					if (ic != hgc_pkg::NONE) begin
						n_ini = ic;
						n_med = hgc_pkg::NONE;
					end else begin
						n_ini = hgc_pkg::NONE;
						n_med = im;
					end
				end else if (!hm) begin
					if (im != hgc_pkg::NONE) begin
						n_med = im;
					end else begin
						do_commit = 1'b1;
						n_ini     = ic;
						n_med     = hgc_pkg::NONE;
						n_fin     = hgc_pkg::NONE;
					end
				end else if (!hf) begin
					if (ifn != hgc_pkg::NONE) begin
						n_fin = ifn;
					end else if (im != hgc_pkg::NONE) begin
						if (comb_m != hgc_pkg::NONE) begin
							n_med = comb_m;
						end else begin
							do_commit = 1'b1;
							n_ini     = hgc_pkg::NONE;
							n_med     = im;
							n_fin     = hgc_pkg::NONE;
						end
					end else begin
						do_commit = 1'b1;
						n_ini     = ic;
						n_med     = hgc_pkg::NONE;
						n_fin     = hgc_pkg::NONE;
					end
				end else begin
					if (im != hgc_pkg::NONE) begin
						// vowel after a final: move (part of) the final over
						do_commit = 1'b1;
						c_fin     = (keep != 5'd0) ? keep : hgc_pkg::NONE;
						n_ini     = hgc_pkg::FIN_TO_INI[move];
						n_med     = im;
						n_fin     = hgc_pkg::NONE;
					end else if (ifn != hgc_pkg::NONE && comb_f != hgc_pkg::NONE) begin
						n_fin = comb_f;
					end else begin
						do_commit = 1'b1;
						n_ini     = ic;
						n_med     = hgc_pkg::NONE;
						n_fin     = hgc_pkg::NONE;
					end
				end
			end
			hgc_pkg::REQ_BKSP: begin
				if (hf) begin
					n_fin = hgc_pkg::NONE;
				end else if (hm) begin
					n_med = hgc_pkg::NONE;
				end else if (hc) begin
					n_ini = hgc_pkg::NONE;
				end else begin
					erase = 1'b1;
					n_ini = hgc_pkg::NONE;
					n_med = hgc_pkg::NONE;
					n_fin = hgc_pkg::NONE;
				end
			end
			hgc_pkg::REQ_FLUSH: begin
				do_commit = 1'b1;
				n_ini     = hgc_pkg::NONE;
				n_med     = hgc_pkg::NONE;
				n_fin     = hgc_pkg::NONE;
			end
			default: begin
				// unused request code: report preedit only
			end
		endcase
	end

	// ---------------------------------------------------------------
	// Result list: commit, raw key, erase, then the preedit report
	// ---------------------------------------------------------------
	hgc_pkg::code_t commit_code;
	hgc_pkg::res_t  slot [3];
	logic [1:0]     n_res;

	always_comb begin
		commit_code = do_commit ? hgc_pkg::compose(c_ini, c_med, c_fin) : 16'd0;
		for (int i = 0; i < 3; i++) begin
			slot[i] = '{kind: hgc_pkg::KIND_PREEDIT, code: 16'd0};
		end
		n_res = 2'd0;
		if (commit_code != 16'd0) begin
			slot[n_res] = '{kind: hgc_pkg::KIND_COMMIT, code: commit_code};
			n_res       = n_res + 2'd1;
		end
		if (raw_key) begin
			slot[n_res] = '{kind: hgc_pkg::KIND_COMMIT, code: {8'd0, key_s1}};
			n_res       = n_res + 2'd1;
		end
		if (erase) begin
			slot[n_res] = '{kind: hgc_pkg::KIND_ERASE, code: 16'd0};
			n_res       = n_res + 2'd1;
		end
		slot[n_res] = '{kind: hgc_pkg::KIND_PREEDIT,
		                code: hgc_pkg::compose(n_ini, n_med, n_fin)};
	end

	// advance the composition state with each processed request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ini_q <= hgc_pkg::NONE;
			med_q <= hgc_pkg::NONE;
			fin_q <= hgc_pkg::NONE;
		end else if (advance) begin
			ini_q <= n_ini;
			med_q <= n_med;
			fin_q <= n_fin;
		end
	end

	// queue count: load a new list, or drop one beat per take
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_left_q <= 2'd0;
		end else if (advance) begin
			res_left_q <= n_res + 2'd1;
		end else if (res_take) begin
			res_left_q <= res_left_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= slot;
		end else if (res_take) begin
			res_s2[0] <= res_s2[1];
			res_s2[1] <= res_s2[2];
		end
	end

	assign res_valid = (res_left_q != 2'd0);
	assign out_kind  = res_s2[0].kind;
	assign char_code = res_s2[0].code;
	assign last      = (res_left_q == 2'd1);

endmodule

`default_nettype wire
